// ===== rtl/core/rtfh_pkg.sv =====
package rtfh_pkg;

   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIR_Z    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_DIST = 3'd6;

   // Operand bank bases: x bank holds dir and e1 = b - a, y bank holds
   // e1, e2 = c - a and the origin offset s = a - origin.
   localparam logic [3:0] X_DIR = 4'd0;
   localparam logic [3:0] X_E1  = 4'd3;
   localparam logic [3:0] Y_E1  = 4'd0;
   localparam logic [3:0] Y_E2  = 4'd3;
   localparam logic [3:0] Y_S   = 4'd6;

   // Cross product bank: p = dir x e2, r = dir x e1, m = e1 x e2.
   localparam logic [3:0] C_P = 4'd0;
   localparam logic [3:0] C_R = 4'd3;
   localparam logic [3:0] C_M = 4'd6;

   // Triple product bank.
   localparam logic [3:0] DOT_D = 4'd0;
   localparam logic [3:0] DOT_U = 4'd1;
   localparam logic [3:0] DOT_V = 4'd2;
   localparam logic [3:0] DOT_T = 4'd3;

   localparam logic [2:0] G_P   = 3'd0;
   localparam logic [2:0] G_R   = 3'd1;
   localparam logic [2:0] G_M   = 3'd2;
   localparam logic [2:0] G_D   = 3'd3;
   localparam logic [2:0] G_U   = 3'd4;
   localparam logic [2:0] G_V   = 3'd5;
   localparam logic [2:0] G_T   = 3'd6;
   localparam logic [2:0] G_END = 3'd7;

   typedef struct packed {
      logic       x_cross;
      logic [3:0] x_idx;
      logic       x_hi;
      logic [3:0] y_idx;
      logic       neg;
      logic       clr;
      logic       wr_cross;
      logic       wr_dot;
      logic [3:0] dst;
   } ucode_type;

   function automatic ucode_type ucode(input logic [2:0] grp, input logic [1:0] comp,
                                       input logic sub);
      ucode_type  u;
      logic [1:0] c1;
      logic [1:0] c2;
      logic [3:0] xb;
      logic [3:0] yb;
      u  = '0;
      c1 = (comp == 2'd2) ? 2'd0 : comp + 2'd1;
      c2 = (comp == 2'd0) ? 2'd2 : comp - 2'd1;
      xb = '0;
      yb = '0;
      case (grp)
         G_P: begin
            xb = X_DIR; yb = Y_E2; u.dst = C_P;
         end
         G_R: begin
            xb = X_DIR; yb = Y_E1; u.dst = C_R;
         end
         G_M: begin
            xb = X_E1; yb = Y_E2; u.dst = C_M;
         end
         G_D: begin
            xb = C_P; yb = Y_E1; u.dst = DOT_D;
         end
         G_U: begin
            xb = C_P; yb = Y_S; u.neg = 1'b1; u.dst = DOT_U;
         end
         G_V: begin
            xb = C_R; yb = Y_S; u.dst = DOT_V;
         end
         G_T: begin
            xb = C_M; yb = Y_S; u.neg = 1'b1; u.dst = DOT_T;
         end
         default: ;
      endcase
      if (grp == G_P || grp == G_R || grp == G_M) begin
         u.x_idx    = xb + {2'b00, (sub ? c2 : c1)};
         u.y_idx    = yb + {2'b00, (sub ? c1 : c2)};
         u.neg      = sub;
         u.clr      = !sub;
         u.wr_cross = sub;
         u.dst      = u.dst + {2'b00, comp};
      end else if (grp != G_END) begin
         u.x_cross = 1'b1;
         u.x_idx   = xb + {2'b00, comp};
         u.x_hi    = sub;
         u.y_idx   = yb + {2'b00, comp};
         u.clr     = (comp == 2'd0) && !sub;
         u.wr_dot  = (comp == 2'd2) && sub;
      end
      return u;
   endfunction

endpackage

// ===== rtl/core/rtfh_if.sv =====
interface rtfh_req_if #(parameter int COORD_WIDTH = 32, parameter int INDEX_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic                          first_of_query;
   logic [INDEX_WIDTH-1:0]        tri_number;
   logic signed [COORD_WIDTH-1:0] a_x;
   logic signed [COORD_WIDTH-1:0] a_y;
   logic signed [COORD_WIDTH-1:0] a_z;
   logic signed [COORD_WIDTH-1:0] b_x;
   logic signed [COORD_WIDTH-1:0] b_y;
   logic signed [COORD_WIDTH-1:0] b_z;
   logic signed [COORD_WIDTH-1:0] c_x;
   logic signed [COORD_WIDTH-1:0] c_y;
   logic signed [COORD_WIDTH-1:0] c_z;

   modport source (output valid, first_of_query, tri_number, a_x, a_y, a_z, b_x, b_y, b_z,
                   c_x, c_y, c_z, input ready);
   modport sink (input valid, first_of_query, tri_number, a_x, a_y, a_z, b_x, b_y, b_z,
                 c_x, c_y, c_z, output ready);
endinterface

interface rtfh_rsp_if #(parameter int COORD_WIDTH = 32, parameter int INDEX_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic                          found;
   logic [INDEX_WIDTH-1:0]        hit_index;
   logic [COORD_WIDTH-2:0]        distance;
   logic signed [COORD_WIDTH-1:0] coord_u;
   logic signed [COORD_WIDTH-1:0] coord_v;

   modport source (output valid, hit, found, hit_index, distance, coord_u, coord_v,
                   input ready);
   modport sink (input valid, hit, found, hit_index, distance, coord_u, coord_v,
                 output ready);
endinterface

interface rtfh_csr_if #(parameter int COORD_WIDTH = 32);
   logic                                 valid;
   logic                                 ready;
   logic [rtfh_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [COORD_WIDTH-1:0]               data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rtfh_div.sv =====
module rtfh_div #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   parameter int NUM_WIDTH   = 102
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [NUM_WIDTH-1:0]   numer,
   input  logic signed [NUM_WIDTH-1:0]   denom,
   output logic                          done,
   output logic signed [COORD_WIDTH-1:0] quot
);

   localparam int RW   = NUM_WIDTH + COORD_WIDTH + FRAC_BITS;
   localparam int CNTW = $clog2(COORD_WIDTH + 1);
   localparam logic signed [COORD_WIDTH+1:0] HI =
      (COORD_WIDTH+2)'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [COORD_WIDTH+1:0] LO = -HI - 1;

   logic [RW-1:0]          rem_ff, rem_in, dsh_ff, dsh_in;
   logic [COORD_WIDTH:0]   q_ff, q_in;
   logic                   neg_ff, neg_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [NUM_WIDTH-1:0]   mag;
   logic                   ge;
   logic signed [COORD_WIDTH+1:0] qx, val;

   always_comb begin
      mag = numer[NUM_WIDTH-1] ? ($unsigned(~numer) + NUM_WIDTH'(1)) : $unsigned(numer);
      ge  = rem_ff >= dsh_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = RW'(mag) << FRAC_BITS;
         dsh_in  = RW'($unsigned(denom)) << COORD_WIDTH;
         neg_in  = numer[NUM_WIDTH-1];
         cnt_in  = CNTW'(COORD_WIDTH);
         q_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[COORD_WIDTH-1:0], ge};
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNTW'(1);
         end
      end
   end

   always_comb begin
      qx = $signed({2'b00, q_ff[COORD_WIDTH-1:0]}) +
           $signed({{(COORD_WIDTH+1){1'b0}}, (neg_ff && (rem_ff != '0))});
      val = neg_ff ? -qx : qx;
      if (q_ff[COORD_WIDTH]) begin
         quot = neg_ff ? LO[COORD_WIDTH-1:0] : HI[COORD_WIDTH-1:0];
      end else if (val > HI) begin
         quot = HI[COORD_WIDTH-1:0];
      end else if (val < LO) begin
         quot = LO[COORD_WIDTH-1:0];
      end else begin
         quot = val[COORD_WIDTH-1:0];
      end
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== rtl/core/ray_triangle_first_hit_core.sv =====
// A triangle that is skipped because the query already has a hit is answered untested;
// a culled or singular one stops after the cross and triple products, and a tested one
// also runs the divisions for t, u and v. The shared multiplier issues 42 steps for the
// cross and triple products and the shared radix-2 divider computes t, u and v in turn.
// One item is in work at a time; ready returns in the cycle after the result is taken.
// Synchronous reset restores the default ray and clears the found flag.
module ray_triangle_first_hit_core #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   parameter int INDEX_WIDTH = 16
) (
   input logic          clock,
   input logic          reset,
   rtfh_req_if.sink     req_chan,
   rtfh_rsp_if.source   rsp_chan,
   rtfh_csr_if.sink     csr_chan
);

   localparam int W      = COORD_WIDTH;
   localparam int EW     = W + 1;
   localparam int XW     = W + 2;
   localparam int L      = W + 1;
   localparam int CW     = 2 * W + 3;
   localparam int PW     = XW + EW;
   localparam int AW     = 3 * W + 6;
   localparam int MARGIN = ((1 << FRAC_BITS) + 500) / 1000;
   localparam int TW     = ((W > FRAC_BITS + 1) ? W : FRAC_BITS + 1) + 2;
   localparam logic signed [TW-1:0] LIMIT = TW'((64'sd1 <<< FRAC_BITS) + MARGIN);
   localparam logic signed [TW-1:0] NMARG = TW'(-MARGIN);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MAC   = 6'b000010,
      ST_CHECK = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_FINAL = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic signed [W-1:0]  org_ff [3];
   logic signed [W-1:0]  dir_ff [3];
   logic [W-2:0]         maxd_ff;

   logic signed [EW-1:0] xs_ff [6];
   logic signed [EW-1:0] ys_ff [9];
   logic signed [CW-1:0] cross_ff [9];
   logic signed [AW-1:0] dot_ff [4];
   logic signed [W-1:0]  res_ff [3];
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   rtfh_pkg::ucode_type  ctl_ff, uc;
   logic                 ctl_vld_ff, ctl_vld_in;
   logic [2:0]           grp_ff, grp_in;
   logic [1:0]           comp_ff, comp_in;
   logic                 sub_ff, sub_in;
   logic [1:0]           sel_ff, sel_in;
   logic                 start_ff, start_in;
   logic                 found_ff, found_in;
   logic [INDEX_WIDTH-1:0] idx_ff, idx_in;

   logic                 o_hit_ff, o_hit_in, o_found_ff, o_found_in;
   logic [INDEX_WIDTH-1:0] o_idx_ff, o_idx_in;
   logic [W-2:0]         o_dist_ff, o_dist_in;
   logic signed [W-1:0]  o_u_ff, o_u_in, o_v_ff, o_v_in;

   logic                 req_acc, found_eff, load_en;
   logic signed [W-1:0]  av [3], bv [3], cv [3];
   logic signed [XW-1:0] xop;
   logic signed [EW-1:0] yop;
   logic signed [AW-1:0] term, base;
   logic signed [AW-1:0] div_num;
   logic                 div_done;
   logic signed [W-1:0]  div_quot;
   logic signed [TW-1:0] ut, vt, uv_sum;
   logic                 d_pos, hit_now;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_RESP);
   assign rsp_chan.hit       = o_hit_ff;
   assign rsp_chan.found     = o_found_ff;
   assign rsp_chan.hit_index = o_idx_ff;
   assign rsp_chan.distance  = o_dist_ff;
   assign rsp_chan.coord_u   = o_u_ff;
   assign rsp_chan.coord_v   = o_v_ff;

   assign av[0] = req_chan.a_x;
   assign av[1] = req_chan.a_y;
   assign av[2] = req_chan.a_z;
   assign bv[0] = req_chan.b_x;
   assign bv[1] = req_chan.b_y;
   assign bv[2] = req_chan.b_z;
   assign cv[0] = req_chan.c_x;
   assign cv[1] = req_chan.c_y;
   assign cv[2] = req_chan.c_z;

   assign req_acc   = req_chan.valid && req_chan.ready;
   assign found_eff = req_chan.first_of_query ? 1'b0 : found_ff;
   assign load_en   = req_acc && !found_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         dir_ff[0] <= W'(64'sd1 <<< FRAC_BITS);
         dir_ff[1] <= '0;
         dir_ff[2] <= '0;
         maxd_ff   <= '1;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            rtfh_pkg::CSR_ORIGIN_X: org_ff[0] <= csr_chan.data;
            rtfh_pkg::CSR_ORIGIN_Y: org_ff[1] <= csr_chan.data;
            rtfh_pkg::CSR_ORIGIN_Z: org_ff[2] <= csr_chan.data;
            rtfh_pkg::CSR_DIR_X:    dir_ff[0] <= csr_chan.data;
            rtfh_pkg::CSR_DIR_Y:    dir_ff[1] <= csr_chan.data;
            rtfh_pkg::CSR_DIR_Z:    dir_ff[2] <= csr_chan.data;
            rtfh_pkg::CSR_MAX_DIST: maxd_ff   <= csr_chan.data[W-2:0];
            default: ;
         endcase
      end
   end

   // Shared multiply-accumulate datapath.
   always_comb begin
      uc = rtfh_pkg::ucode(grp_ff, comp_ff, sub_ff);
      if (uc.x_cross) begin
         if (uc.x_hi) begin
            xop = $signed(cross_ff[uc.x_idx][CW-1:L]);
         end else begin
            xop = $signed({1'b0, cross_ff[uc.x_idx][L-1:0]});
         end
      end else begin
         xop = XW'(xs_ff[uc.x_idx[2:0]]);
      end
      yop     = ys_ff[uc.y_idx];
      prod_in = xop * yop;
      term    = ctl_ff.x_hi ? (AW'(prod_ff) <<< L) : AW'(prod_ff);
      base    = ctl_ff.clr ? '0 : acc_ff;
      acc_in  = ctl_ff.neg ? base - term : base + term;
   end

   always_comb begin
      case (sel_ff)
         2'd0:    div_num = dot_ff[rtfh_pkg::DOT_T[1:0]];
         2'd1:    div_num = dot_ff[rtfh_pkg::DOT_U[1:0]];
         default: div_num = dot_ff[rtfh_pkg::DOT_V[1:0]];
      endcase
   end

   rtfh_div #(
      .COORD_WIDTH (W),
      .FRAC_BITS   (FRAC_BITS),
      .NUM_WIDTH   (AW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .numer (div_num),
      .denom (dot_ff[rtfh_pkg::DOT_D[1:0]]),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      d_pos   = !dot_ff[rtfh_pkg::DOT_D[1:0]][AW-1] && (dot_ff[rtfh_pkg::DOT_D[1:0]] != '0);
      ut      = TW'(res_ff[1]);
      vt      = TW'(res_ff[2]);
      uv_sum  = ut + vt;
      hit_now = (uv_sum < LIMIT) && (ut > NMARG) && (vt > NMARG) && !res_ff[0][W-1] &&
                ($unsigned(res_ff[0]) < {1'b0, maxd_ff});
   end

   always_comb begin
      state_in   = state_ff;
      grp_in     = grp_ff;
      comp_in    = comp_ff;
      sub_in     = sub_ff;
      sel_in     = sel_ff;
      start_in   = 1'b0;
      found_in   = found_ff;
      idx_in     = idx_ff;
      ctl_vld_in = 1'b0;
      o_hit_in   = o_hit_ff;
      o_found_in = o_found_ff;
      o_idx_in   = o_idx_ff;
      o_dist_in  = o_dist_ff;
      o_u_in     = o_u_ff;
      o_v_in     = o_v_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               found_in   = found_eff;
               idx_in     = req_chan.tri_number;
               o_hit_in   = 1'b0;
               o_found_in = found_eff;
               o_idx_in   = '0;
               o_dist_in  = '0;
               o_u_in     = '0;
               o_v_in     = '0;
               grp_in     = rtfh_pkg::G_P;
               comp_in    = '0;
               sub_in     = 1'b0;
               state_in   = found_eff ? ST_RESP : ST_MAC;
            end
         end
         ST_MAC: begin
            if (grp_ff == rtfh_pkg::G_END) begin
               state_in = ST_CHECK;
            end else begin
               ctl_vld_in = 1'b1;
               sub_in     = !sub_ff;
               if (sub_ff) begin
                  if (comp_ff == 2'd2) begin
                     comp_in = '0;
                     grp_in  = grp_ff + 3'd1;
                  end else begin
                     comp_in = comp_ff + 2'd1;
                  end
               end
            end
         end
         ST_CHECK: begin
            if (d_pos) begin
               sel_in   = '0;
               start_in = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (sel_ff == 2'd2) begin
                  state_in = ST_FINAL;
               end else begin
                  sel_in   = sel_ff + 2'd1;
                  start_in = 1'b1;
               end
            end
         end
         ST_FINAL: begin
            if (hit_now) begin
               found_in   = 1'b1;
               o_hit_in   = 1'b1;
               o_found_in = 1'b1;
               o_idx_in   = idx_ff;
               o_dist_in  = res_ff[0][W-2:0];
               o_u_in     = res_ff[1];
               o_v_in     = res_ff[2];
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         for (int i = 0; i < 3; i++) begin
            xs_ff[i]     <= EW'(dir_ff[i]);
            xs_ff[i + 3] <= EW'(bv[i]) - EW'(av[i]);
            ys_ff[i]     <= EW'(bv[i]) - EW'(av[i]);
            ys_ff[i + 3] <= EW'(cv[i]) - EW'(av[i]);
            ys_ff[i + 6] <= EW'(av[i]) - EW'(org_ff[i]);
         end
      end
      prod_ff <= prod_in;
      ctl_ff  <= uc;
      if (ctl_vld_ff) begin
         acc_ff <= acc_in;
         if (ctl_ff.wr_cross) begin
            cross_ff[ctl_ff.dst] <= acc_in[CW-1:0];
         end
         if (ctl_ff.wr_dot) begin
            dot_ff[ctl_ff.dst[1:0]] <= acc_in;
         end
      end
      if (state_ff == ST_DIV && div_done) begin
         res_ff[sel_ff] <= div_quot;
      end
      grp_ff    <= grp_in;
      comp_ff   <= comp_in;
      sub_ff    <= sub_in;
      sel_ff    <= sel_in;
      idx_ff    <= idx_in;
      o_hit_ff  <= o_hit_in;
      o_found_ff <= o_found_in;
      o_idx_ff  <= o_idx_in;
      o_dist_ff <= o_dist_in;
      o_u_ff    <= o_u_in;
      o_v_ff    <= o_v_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         ctl_vld_ff <= 1'b0;
         start_ff   <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ctl_vld_ff <= ctl_vld_in;
         start_ff   <= start_in;
         found_ff   <= found_in;
      end
   end

endmodule

// ===== dv/tb_ray_triangle_first_hit_core.sv =====
module tb_ray_triangle_first_hit_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int INDEX_WIDTH = 16;
   localparam logic [rtfh_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 3'd7;
   localparam longint UNIT   = 64'sd1 <<< FRAC_BITS;
   localparam longint MARGIN = ((64'sd1 <<< FRAC_BITS) + 500) / 1000;

   typedef logic signed [191:0] wide_type;
   typedef wide_type vec_type [3];
   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct {
      logic                   first;
      logic [INDEX_WIDTH-1:0] number;
      coord_type              va[3];
      coord_type              vb[3];
      coord_type              vc[3];
   } triangle_type;

   typedef struct {
      logic                   hit;
      logic                   found;
      logic [INDEX_WIDTH-1:0] index;
      logic [COORD_WIDTH-2:0] distance;
      coord_type              u;
      coord_type              v;
   } hit_result_type;

   logic clock;
   logic reset;

   rtfh_req_if #(.COORD_WIDTH(COORD_WIDTH), .INDEX_WIDTH(INDEX_WIDTH)) req_chan();
   rtfh_rsp_if #(.COORD_WIDTH(COORD_WIDTH), .INDEX_WIDTH(INDEX_WIDTH)) rsp_chan();
   rtfh_csr_if #(.COORD_WIDTH(COORD_WIDTH)) csr_chan();

   ray_triangle_first_hit_core #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS(FRAC_BITS),
      .INDEX_WIDTH(INDEX_WIDTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   coord_type              ray_origin[3];
   coord_type              ray_dir[3];
   logic [COORD_WIDTH-2:0] ray_max_dist;
   logic                   query_found = 1'b0;

   triangle_type   pending_tris[$];
   hit_result_type expected_hits[$];
   int          sent_count;
   int          taken_count;
   int          results_seen;
   int          error_count;
   bit          quiet;
   int          send_gap;
   int          recv_stall;
   int          long_hold;
   bit          hold_done;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic vec_type cross3(vec_type p, vec_type q);
      vec_type r;
      r[0] = p[1] * q[2] - p[2] * q[1];
      r[1] = p[2] * q[0] - p[0] * q[2];
      r[2] = p[0] * q[1] - p[1] * q[0];
      return r;
   endfunction

   function automatic wide_type dot3(vec_type p, vec_type q);
      return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
   endfunction

   function automatic longint floor_sat(wide_type num, wide_type den);
      wide_type q;
      q = num / den;
      if (num < 0 && q * den != num)
         q = q - 1;
      if (q > wide_type'(64'sd2147483647))
         return 64'sd2147483647;
      if (q < -wide_type'(64'sd2147483648))
         return -64'sd2147483648;
      return longint'(q);
   endfunction

   function automatic hit_result_type trace_triangle(triangle_type tr);
      vec_type        e1, e2, s, dv, n, tmp;
      wide_type       den;
      longint         t, u, v;
      hit_result_type r;
      r = '{default: '0};
      if (tr.first)
         query_found = 1'b0;
      if (!query_found) begin
         for (int i = 0; i < 3; i++) begin
            e1[i] = wide_type'(tr.vb[i]) - wide_type'(tr.va[i]);
            e2[i] = wide_type'(tr.vc[i]) - wide_type'(tr.va[i]);
            s[i]  = wide_type'(tr.va[i]) - wide_type'(ray_origin[i]);
            dv[i] = wide_type'(ray_dir[i]);
         end
         n   = cross3(e2, e1);
         den = dot3(n, dv);
         if (den > 0) begin
            t   = floor_sat(dot3(s, n) * UNIT, den);
            tmp = cross3(s, e2);
            u   = floor_sat(dot3(dv, tmp) * UNIT, den);
            tmp = cross3(e1, s);
            v   = floor_sat(dot3(dv, tmp) * UNIT, den);
            if (u + v < UNIT + MARGIN && u > -MARGIN && v > -MARGIN && t >= 0 &&
                t < longint'({33'b0, ray_max_dist})) begin
               query_found = 1'b1;
               r.hit      = 1'b1;
               r.index    = tr.number;
               r.distance = t[COORD_WIDTH-2:0];
               r.u        = u[COORD_WIDTH-1:0];
               r.v        = v[COORD_WIDTH-1:0];
            end
         end
      end
      r.found = query_found;
      return r;
   endfunction

   function automatic triangle_type plane_tri(logic first, int num, coord_type x, coord_type y,
                                              coord_type z, coord_type size, bit flip);
      triangle_type tr;
      tr.first  = first;
      tr.number = num[INDEX_WIDTH-1:0];
      tr.va     = '{x, y, z};
      tr.vb     = '{x, y, z + size};
      tr.vc     = '{x, y + size, z};
      if (flip) begin
         tr.vb = tr.vc;
         tr.vc = '{x, y, z + size};
      end
      return tr;
   endfunction

   function automatic triangle_type noise_tri(logic first);
      triangle_type tr;
      tr.first  = first;
      tr.number = $urandom;
      for (int i = 0; i < 3; i++) begin
         tr.va[i] = $urandom;
         tr.vb[i] = $urandom;
         tr.vc[i] = $urandom;
      end
      return tr;
   endfunction

   // Builds a triangle around a point on the ray, so that most of them are hit
   // when facing the ray.
   function automatic triangle_type aimed_tri(logic first);
      triangle_type tr;
      longint       tt, uu, vv, p, e1, e2;
      coord_type    swap;
      tt = longint'($urandom_range(0, 1 << 21)) - (1 << 18);
      uu = longint'($urandom_range(0, 50000)) - 2000;
      vv = longint'($urandom_range(0, 50000)) - 2000;
      tr.first  = first;
      tr.number = $urandom;
      for (int i = 0; i < 3; i++) begin
         p  = longint'(ray_origin[i]) + ((tt * longint'(ray_dir[i])) >>> FRAC_BITS);
         e1 = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
         e2 = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
         p  = p - ((uu * e1 + vv * e2) >>> FRAC_BITS);
         tr.va[i] = p[COORD_WIDTH-1:0];
         tr.vb[i] = tr.va[i] + coord_type'(e1);
         tr.vc[i] = tr.va[i] + coord_type'(e2);
      end
      if ($urandom_range(0, 3) == 0) begin
         for (int i = 0; i < 3; i++) begin
            swap     = tr.vb[i];
            tr.vb[i] = tr.vc[i];
            tr.vc[i] = swap;
         end
      end
      return tr;
   endfunction

   task automatic write_reg(logic [rtfh_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [COORD_WIDTH-1:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do
         @(posedge clock);
      while (!csr_chan.ready);
      case (idx)
         rtfh_pkg::CSR_ORIGIN_X: ray_origin[0] = data;
         rtfh_pkg::CSR_ORIGIN_Y: ray_origin[1] = data;
         rtfh_pkg::CSR_ORIGIN_Z: ray_origin[2] = data;
         rtfh_pkg::CSR_DIR_X:    ray_dir[0] = data;
         rtfh_pkg::CSR_DIR_Y:    ray_dir[1] = data;
         rtfh_pkg::CSR_DIR_Z:    ray_dir[2] = data;
         rtfh_pkg::CSR_MAX_DIST: ray_max_dist = data[COORD_WIDTH-2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic write_ray(coord_type ox, coord_type oy, coord_type oz, coord_type dx,
                            coord_type dy, coord_type dz, logic [COORD_WIDTH-2:0] maxd);
      write_reg(rtfh_pkg::CSR_ORIGIN_X, ox);
      write_reg(rtfh_pkg::CSR_ORIGIN_Y, oy);
      write_reg(rtfh_pkg::CSR_ORIGIN_Z, oz);
      write_reg(rtfh_pkg::CSR_DIR_X, dx);
      write_reg(rtfh_pkg::CSR_DIR_Y, dy);
      write_reg(rtfh_pkg::CSR_DIR_Z, dz);
      write_reg(rtfh_pkg::CSR_MAX_DIST, {1'b0, maxd});
   endtask

   task automatic drain();
      wait (pending_tris.size() == 0 && sent_count == taken_count &&
            expected_hits.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic queue_random(int count, int noise_pct);
      logic first;
      int   left;
      left = 0;
      for (int k = 0; k < count; k++) begin
         first = (left == 0) || ($urandom_range(0, 30) == 0);
         if (first)
            left = $urandom_range(1, 8);
         left--;
         if ($urandom_range(0, 99) < noise_pct)
            pending_tris.push_back(noise_tri(first));
         else
            pending_tris.push_back(aimed_tri(first));
      end
   endtask

   task automatic random_ray(logic [COORD_WIDTH-2:0] maxd);
      write_ray($urandom_range(0, 1 << 21) - (1 << 20), $urandom_range(0, 1 << 21) - (1 << 20),
                $urandom_range(0, 1 << 21) - (1 << 20), $urandom_range(0, 1 << 18) - (1 << 17),
                $urandom_range(0, 1 << 18) - (1 << 17), $urandom_range(0, 1 << 18) - (1 << 17),
                maxd);
   endtask

   // Sender: one item in flight at a time, gaps in random bursts.
   always @(negedge clock) begin
      triangle_type tr;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (sent_count == taken_count) begin
         if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_tris.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 16);
            req_chan.valid <= 1'b0;
         end else if (pending_tris.size() > 0) begin
            tr = pending_tris.pop_front();
            req_chan.valid          <= 1'b1;
            req_chan.first_of_query <= tr.first;
            req_chan.tri_number     <= tr.number;
            req_chan.a_x <= tr.va[0];
            req_chan.a_y <= tr.va[1];
            req_chan.a_z <= tr.va[2];
            req_chan.b_x <= tr.vb[0];
            req_chan.b_y <= tr.vb[1];
            req_chan.b_z <= tr.vb[2];
            req_chan.c_x <= tr.vc[0];
            req_chan.c_y <= tr.vc[1];
            req_chan.c_z <= tr.vc[2];
            sent_count++;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      triangle_type tr;
      if (!reset && req_chan.valid && req_chan.ready) begin
         tr.first  = req_chan.first_of_query;
         tr.number = req_chan.tri_number;
         tr.va     = '{req_chan.a_x, req_chan.a_y, req_chan.a_z};
         tr.vb     = '{req_chan.b_x, req_chan.b_y, req_chan.b_z};
         tr.vc     = '{req_chan.c_x, req_chan.c_y, req_chan.c_z};
         expected_hits.push_back(trace_triangle(tr));
         taken_count++;
      end
   end

   always @(negedge clock) begin
      if (!hold_done && results_seen == 30) begin
         hold_done = 1'b1;
         long_hold = 600;
      end
      if (long_hold > 0)
         long_hold--;
   end

   always @(negedge clock) begin
      if (long_hold > 0) begin
         rsp_chan.ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_chan.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         recv_stall = $urandom_range(0, 16);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      hit_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (expected_hits.size() == 0) begin
            $display("%0t: result with none expected: hit %0b found %0b", $time,
                     rsp_chan.hit, rsp_chan.found);
            error_count++;
         end else begin
            want = expected_hits.pop_front();
            if (rsp_chan.hit !== want.hit || rsp_chan.found !== want.found ||
                rsp_chan.hit_index !== want.index || rsp_chan.distance !== want.distance ||
                rsp_chan.coord_u !== want.u || rsp_chan.coord_v !== want.v) begin
               $display("%0t: expected hit %0b found %0b index %0d dist %0h u %0h v %0h",
                        $time, want.hit, want.found, want.index, want.distance, want.u,
                        want.v);
               $display("%0t: actual   hit %0b found %0b index %0d dist %0h u %0h v %0h",
                        $time, rsp_chan.hit, rsp_chan.found, rsp_chan.hit_index,
                        rsp_chan.distance, rsp_chan.coord_u, rsp_chan.coord_v);
               error_count++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("FAIL ray_triangle_first_hit_core");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data  = '0;
      ray_origin   = '{0, 0, 0};
      ray_dir      = '{coord_type'(UNIT), 0, 0};
      ray_max_dist = '1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset ray runs along +x from the origin.
      pending_tris.push_back(plane_tri(1, 0, 32'sh50000, -32'sh8000, -32'sh8000,
                                       32'sh20000, 0));
      pending_tris.push_back(plane_tri(0, 1, 32'sh10000, -32'sh8000, -32'sh8000,
                                       32'sh20000, 0));
      pending_tris.push_back(plane_tri(1, 16'hffff, 32'sh50000, -32'sh8000, -32'sh8000,
                                       32'sh20000, 1));
      pending_tris.push_back(plane_tri(0, 3, 32'sh50000, 0, 0, 0, 0));
      pending_tris.push_back(plane_tri(0, 4, -32'sh50000, -32'sh8000, -32'sh8000,
                                       32'sh20000, 0));
      pending_tris.push_back(plane_tri(0, 5, 32'sh30000, 32'sh100, 32'sh100, 32'sh20000, 0));
      pending_tris.push_back(plane_tri(0, 6, 32'sh30000, 0, 0, 32'sh20000, 0));
      pending_tris.push_back(plane_tri(1, 7, 32'sh30000, -32'sh20, -32'sh20, 32'sh10000, 0));
      pending_tris.push_back(plane_tri(1, 8, 32'sh30000, -32'sh50, -32'sh50, 32'sh80, 0));
      pending_tris.push_back(plane_tri(1, 9, 0, -32'sh8000, -32'sh8000, 32'sh20000, 0));
      pending_tris.push_back(plane_tri(1, 10, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                                       32'sh7fffffff, 0));
      pending_tris.push_back(plane_tri(1, 11, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                                       32'sh80000000, 0));
      pending_tris.push_back(plane_tri(1, 12, 32'sh1, -32'sh1, -32'sh1, 32'sh7fffffff, 0));
      pending_tris.push_back(plane_tri(1, 13, 32'sh7fff0000, -32'sh1, -32'sh1, 32'sh3, 0));
      for (int k = 0; k < 6; k++)
         pending_tris.push_back(noise_tri(k[0]));
      drain();

      random_ray($urandom_range(1 << 20, 31'h7fffffff));
      write_reg(CSR_UNUSED, $urandom);
      queue_random(380, 15);
      drain();

      write_ray(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                32'sh7fffffff, '0);
      queue_random(40, 30);
      drain();
      write_ray(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                32'sh80000000, '1);
      queue_random(40, 30);
      drain();

      random_ray('1);
      queue_random(400, 15);
      drain();

      random_ray($urandom_range(0, 1 << 19));
      queue_random(400, 15);
      drain();

      random_ray('1);
      quiet = 1'b1;
      queue_random(370, 15);
      drain();
      repeat (250) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS ray_triangle_first_hit_core");
      end else begin
         $display("FAIL ray_triangle_first_hit_core");
      end
      $finish;
   end

endmodule
